### rtl/core/solh_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// solh_pkg
// Shared constants, codes and types of the open-list min-heap.
// ---------------------------------------------------------------------------
package solh_pkg;

  localparam int DEF_CAPACITY   = 1024;
  localparam int DEF_COST_BITS  = 32;
  localparam int DEF_COORD_BITS = 16;
  localparam int OUT_COUNT_BITS = 11;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_EXTRACT  = 2'd1,
    CMD_DECREASE = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CMP,
    S_EX_LAST,
    S_EX_GET,
    S_DN_ISSUE,
    S_DN_L,
    S_DN_R,
    S_SRCH,
    S_WR_CUR,
    S_DONE
  } solh_state_t;

endpackage
`default_nettype wire

### rtl/core/solh_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// solh interfaces
// Command, result and configuration channels with valid/ready.
// ---------------------------------------------------------------------------
interface solh_cmd_if #(
  parameter int COST_BITS  = 32,
  parameter int COORD_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            command;
  logic [COST_BITS-1:0]  entry_f;
  logic [COST_BITS-1:0]  entry_g;
  logic [COORD_BITS-1:0] entry_x;
  logic [COORD_BITS-1:0] entry_y;
  modport source (output valid, command, entry_f, entry_g, entry_x, entry_y, input ready);
  modport sink   (input valid, command, entry_f, entry_g, entry_x, entry_y, output ready);
endinterface

interface solh_res_if #(
  parameter int COST_BITS  = 32,
  parameter int COORD_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [COST_BITS-1:0]  out_f;
  logic [COST_BITS-1:0]  out_g;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic [1:0]            status;
  logic [10:0]           count_after;
  logic [COST_BITS-1:0]  new_top_f;
  modport source (output valid, out_f, out_g, out_x, out_y, status, count_after, new_top_f,
                  input ready);
  modport sink   (input valid, out_f, out_g, out_x, out_y, status, count_after, new_top_f,
                  output ready);
endinterface

interface solh_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

### rtl/core/solh_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// solh_ram
// Single-port-write, single-port-read memory with registered read data.
// ---------------------------------------------------------------------------
module solh_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/core/search_open_list_min_heap.sv
`default_nettype none
// ---------------------------------------------------------------------------
// search_open_list_min_heap
// Open-list min-heap ordered by f, ties on g, with insert, extract, decrease.
// ---------------------------------------------------------------------------
// One command is processed at a time; the heap lives in a single memory with
// one write port and one registered read port. Insert compares the entry with
// its parent once per level climbed, with an extra write when the entry
// reaches the root. Extract reads the root and the last entry, then reads the
// children and moves one entry per level descended. Decrease key runs a linear
// search followed by a sift up. A finished result is held in an output
// register while the next command is already accepted.
module search_open_list_min_heap
  import solh_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int COST_BITS  = DEF_COST_BITS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input wire logic clk,
  input wire logic rst,
  solh_cmd_if.sink   cmd,
  solh_res_if.source res,
  solh_cfg_if.sink   cfg
);

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int LW      = IDX_W + 2;
  localparam int POS_W   = 2 * COORD_BITS;
  localparam int ENTRY_W = 2 * COST_BITS + POS_W;

  solh_state_t state, state_next;

  logic                 pref;
  logic [CNT_W-1:0]     count, count_next;
  logic [IDX_W-1:0]     k, k_next;
  logic [COST_BITS-1:0] cur_f, cur_f_next, cur_g, cur_g_next;
  logic [POS_W-1:0]     cur_pos, cur_pos_next;
  logic [COST_BITS-1:0] lf_f, lf_f_next, lf_g, lf_g_next;
  logic [POS_W-1:0]     lf_pos, lf_pos_next;
  logic [CNT_W-1:0]     sidx, sidx_next;
  logic [IDX_W-1:0]     cidx, cidx_next;
  logic                 cvalid, cvalid_next;
  logic [COST_BITS-1:0] root_f;
  status_t              st, st_next;
  logic [COST_BITS-1:0] ex_f, ex_f_next, ex_g, ex_g_next;
  logic [POS_W-1:0]     ex_pos, ex_pos_next;

  logic                 res_valid;
  logic [COST_BITS-1:0] r_f, r_g, r_top;
  logic [POS_W-1:0]     r_pos;
  status_t              r_st;
  logic [CNT_W-1:0]     r_cnt;

  logic                 we, re;
  logic [IDX_W-1:0]     waddr, raddr;
  logic [ENTRY_W-1:0]   wdata, rdata;

  logic [COST_BITS-1:0] rd_f, rd_g;
  logic [POS_W-1:0]     rd_pos, in_pos;
  logic [IDX_W-1:0]     pidx, ins_pidx, cidx_pidx, last_idx;
  logic [LW-1:0]        lft, rgt, cnt_ext;
  logic                 accept, has_l, has_r, up_sink, dn_l_sink, sl, br;
  logic                 match, issue, res_free;
  logic [COST_BITS-1:0] bf, bg;

  function automatic logic sinks(input logic [COST_BITS-1:0] fa, input logic [COST_BITS-1:0] ga,
                                 input logic [COST_BITS-1:0] fb, input logic [COST_BITS-1:0] gb,
                                 input logic p);
    logic r;
    if (fa != fb) r = fa > fb;
    else if (p)   r = ga >= gb;
    else          r = ga <= gb;
    return r;
  endfunction

  solh_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY), .AW(IDX_W)) u_ram (
    .clk, .we, .waddr, .wdata, .re, .raddr, .rdata
  );

  assign rd_f   = rdata[ENTRY_W-1 -: COST_BITS];
  assign rd_g   = rdata[POS_W +: COST_BITS];
  assign rd_pos = rdata[POS_W-1:0];
  assign in_pos = {cmd.entry_y, cmd.entry_x};

  assign accept    = cmd.valid && cmd.ready;
  assign pidx      = IDX_W'((k - IDX_W'(1)) >> 1);
  assign ins_pidx  = IDX_W'((count[IDX_W-1:0] - IDX_W'(1)) >> 1);
  assign cidx_pidx = IDX_W'((cidx - IDX_W'(1)) >> 1);
  assign last_idx  = IDX_W'(count - CNT_W'(1));
  assign lft       = LW'({k, 1'b1});
  assign rgt       = lft + LW'(1);
  assign cnt_ext   = LW'(count);
  assign has_l     = lft < cnt_ext;
  assign has_r     = rgt < cnt_ext;
  assign up_sink   = sinks(rd_f, rd_g, cur_f, cur_g, pref);
  assign dn_l_sink = sinks(cur_f, cur_g, rd_f, rd_g, pref);
  assign sl        = sinks(cur_f, cur_g, lf_f, lf_g, pref);
  assign bf        = sl ? lf_f : cur_f;
  assign bg        = sl ? lf_g : cur_g;
  assign br        = sinks(bf, bg, rd_f, rd_g, pref);
  assign match     = cvalid && (rd_pos == cur_pos);
  assign issue     = sidx < count;
  assign res_free  = !res_valid || res.ready;

  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd.command)
            CMD_INSERT: begin
              if (count == CNT_W'(CAPACITY) || count == '0) state_next = S_DONE;
              else state_next = S_UP_CMP;
            end
            CMD_EXTRACT:  state_next = (count == '0) ? S_DONE : S_EX_LAST;
            CMD_DECREASE: state_next = (count == '0) ? S_DONE : S_SRCH;
            default:      state_next = S_DONE;
          endcase
        end
      end
      S_UP_CMP: begin
        if (up_sink) state_next = (pidx == '0) ? S_WR_CUR : S_UP_CMP;
        else state_next = S_DONE;
      end
      S_EX_LAST:  state_next = (last_idx == '0) ? S_DONE : S_EX_GET;
      S_EX_GET:   state_next = S_DN_ISSUE;
      S_DN_ISSUE: state_next = has_l ? S_DN_L : S_WR_CUR;
      S_DN_L: begin
        if (has_r) state_next = S_DN_R;
        else state_next = dn_l_sink ? S_DN_ISSUE : S_WR_CUR;
      end
      S_DN_R:     state_next = (br || sl) ? S_DN_ISSUE : S_WR_CUR;
      S_SRCH: begin
        if (match) state_next = (cidx == '0) ? S_WR_CUR : S_UP_CMP;
        else if (!issue) state_next = S_DONE;
      end
      S_WR_CUR:   state_next = S_DONE;
      S_DONE:     state_next = res_free ? S_IDLE : S_DONE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    count_next   = count;
    k_next       = k;
    cur_f_next   = cur_f;
    cur_g_next   = cur_g;
    cur_pos_next = cur_pos;
    lf_f_next    = lf_f;
    lf_g_next    = lf_g;
    lf_pos_next  = lf_pos;
    sidx_next    = sidx;
    cidx_next    = cidx;
    cvalid_next  = 1'b0;
    st_next      = st;
    ex_f_next    = ex_f;
    ex_g_next    = ex_g;
    ex_pos_next  = ex_pos;
    we    = 1'b0;
    waddr = k;
    wdata = {cur_f, cur_g, cur_pos};
    re    = 1'b0;
    raddr = pidx;
    case (state)
      S_IDLE: begin
        if (accept) begin
          st_next      = ST_OK;
          ex_f_next    = '0;
          ex_g_next    = '0;
          ex_pos_next  = '0;
          cur_f_next   = cmd.entry_f;
          cur_g_next   = cmd.entry_g;
          cur_pos_next = in_pos;
          sidx_next    = '0;
          case (cmd.command)
            CMD_INSERT: begin
              if (count == CNT_W'(CAPACITY)) begin
                st_next = ST_FULL;
              end else begin
                k_next     = count[IDX_W-1:0];
                count_next = count + CNT_W'(1);
                if (count == '0) begin
                  we    = 1'b1;
                  waddr = '0;
                  wdata = {cmd.entry_f, cmd.entry_g, in_pos};
                end else begin
                  re    = 1'b1;
                  raddr = ins_pidx;
                end
              end
            end
            CMD_EXTRACT: begin
              if (count == '0) st_next = ST_EMPTY;
              else begin
                re    = 1'b1;
                raddr = '0;
              end
            end
            CMD_DECREASE: begin
              if (count == '0) st_next = ST_NOTFOUND;
            end
            default: ;
          endcase
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (up_sink) begin
          wdata  = rdata;
          k_next = pidx;
          re     = 1'b1;
          raddr  = IDX_W'((pidx - IDX_W'(1)) >> 1);
        end
      end
      S_EX_LAST: begin
        ex_f_next   = rd_f;
        ex_g_next   = rd_g;
        ex_pos_next = rd_pos;
        count_next  = count - CNT_W'(1);
        re          = 1'b1;
        raddr       = last_idx;
      end
      S_EX_GET: begin
        cur_f_next   = rd_f;
        cur_g_next   = rd_g;
        cur_pos_next = rd_pos;
        k_next       = '0;
      end
      S_DN_ISSUE: begin
        if (has_l) begin
          re    = 1'b1;
          raddr = lft[IDX_W-1:0];
        end
      end
      S_DN_L: begin
        lf_f_next   = rd_f;
        lf_g_next   = rd_g;
        lf_pos_next = rd_pos;
        if (has_r) begin
          re    = 1'b1;
          raddr = rgt[IDX_W-1:0];
        end else if (dn_l_sink) begin
          we     = 1'b1;
          wdata  = rdata;
          k_next = lft[IDX_W-1:0];
        end
      end
      S_DN_R: begin
        if (br) begin
          we     = 1'b1;
          wdata  = rdata;
          k_next = rgt[IDX_W-1:0];
        end else if (sl) begin
          we     = 1'b1;
          wdata  = {lf_f, lf_g, lf_pos};
          k_next = lft[IDX_W-1:0];
        end
      end
      S_SRCH: begin
        if (match) begin
          k_next = cidx;
          if (cidx != '0) begin
            re    = 1'b1;
            raddr = cidx_pidx;
          end
        end else if (issue) begin
          re          = 1'b1;
          raddr       = sidx[IDX_W-1:0];
          cidx_next   = sidx[IDX_W-1:0];
          sidx_next   = sidx + CNT_W'(1);
          cvalid_next = 1'b1;
        end else begin
          st_next = ST_NOTFOUND;
        end
      end
      S_WR_CUR: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pref      <= 1'b1;
      cvalid    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      cvalid <= cvalid_next;
      if (cfg.valid && cfg.ready) pref <= cfg.data;
      if (state == S_DONE && res_free) res_valid <= 1'b1;
      else if (res.ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    k       <= k_next;
    cur_f   <= cur_f_next;
    cur_g   <= cur_g_next;
    cur_pos <= cur_pos_next;
    lf_f    <= lf_f_next;
    lf_g    <= lf_g_next;
    lf_pos  <= lf_pos_next;
    sidx    <= sidx_next;
    cidx    <= cidx_next;
    st      <= st_next;
    ex_f    <= ex_f_next;
    ex_g    <= ex_g_next;
    ex_pos  <= ex_pos_next;
    if (we && waddr == '0) root_f <= wdata[ENTRY_W-1 -: COST_BITS];
    if (state == S_DONE && res_free) begin
      r_f   <= ex_f;
      r_g   <= ex_g;
      r_pos <= ex_pos;
      r_st  <= st;
      r_cnt <= count;
      r_top <= (count != '0) ? root_f : '0;
    end
  end

  assign res.valid       = res_valid;
  assign res.out_f       = r_f;
  assign res.out_g       = r_g;
  assign res.out_x       = r_pos[COORD_BITS-1:0];
  assign res.out_y       = r_pos[POS_W-1:COORD_BITS];
  assign res.status      = r_st;
  assign res.count_after = OUT_COUNT_BITS'(r_cnt);
  assign res.new_top_f   = r_top;

endmodule
`default_nettype wire

### rtl/core/solh_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// solh_checker
// Port-level checks of the open-list heap results.
// ---------------------------------------------------------------------------
module solh_checker
  import solh_pkg::*;
#(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int COST_BITS = DEF_COST_BITS
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 res_valid,
  input wire logic                 res_ready,
  input wire logic [1:0]           res_status,
  input wire logic [10:0]          res_count,
  input wire logic [COST_BITS-1:0] res_f,
  input wire logic [COST_BITS-1:0] res_top
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_count))
    else $error("stalled result changed");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_count == 11'd0 |-> res_top == '0)
    else $error("empty heap reports a top");

  a_empty_extract: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == ST_EMPTY |-> res_f == '0 && res_count == 11'd0)
    else $error("empty extract with data");

  a_full: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == ST_FULL |-> res_count == 11'(CAPACITY))
    else $error("full status with spare room");

endmodule

bind search_open_list_min_heap solh_checker #(
  .CAPACITY(CAPACITY), .COST_BITS(COST_BITS)
) u_solh_checker (
  .clk(clk), .rst(rst), .res_valid(res.valid), .res_ready(res.ready),
  .res_status(res.status), .res_count(res.count_after), .res_f(res.out_f),
  .res_top(res.new_top_f)
);
`default_nettype wire

### bench/tb_search_open_list_min_heap.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_search_open_list_min_heap
// Drives insert, extract-minimum and decrease-key words into the open-list
// heap, mirrors the heap in a scoreboard and checks every result word field
// by field. Covers empty, full and not-found cases, both tie-break settings
// and random gaps on the command and result channels.
// ---------------------------------------------------------------------------
import solh_pkg::*;

typedef struct packed {
  logic [31:0] f;
  logic [31:0] g;
  logic [15:0] x;
  logic [15:0] y;
  logic [1:0]  st;
  logic [10:0] cnt;
  logic [31:0] top;
} heap_result_t;

class heap_scoreboard;
  localparam int CAP = 1024;
  logic [31:0] hf[CAP];
  logic [31:0] hg[CAP];
  logic [31:0] hp[CAP];
  int unsigned n;
  bit small_g;
  heap_result_t pending[$];
  int errors;
  int checked;

  function new();
    n = 0;
    small_g = 1;
    errors = 0;
    checked = 0;
  endfunction

  function bit sinks(int a, int b);
    if (hf[a] != hf[b]) return hf[a] > hf[b];
    if (small_g) return hg[a] >= hg[b];
    return hg[a] <= hg[b];
  endfunction

  function void swap(int a, int b);
    logic [31:0] t;
    t = hf[a]; hf[a] = hf[b]; hf[b] = t;
    t = hg[a]; hg[a] = hg[b]; hg[b] = t;
    t = hp[a]; hp[a] = hp[b]; hp[b] = t;
  endfunction

  function void climb(int k);
    int up;
    while (k > 0) begin
      up = (k - 1) / 2;
      if (!sinks(up, k)) break;
      swap(up, k);
      k = up;
    end
  endfunction

  function void descend();
    int k, l, r, b;
    k = 0;
    forever begin
      l = 2 * k + 1;
      r = 2 * k + 2;
      b = k;
      if (l < n && sinks(k, l)) b = l;
      if (r < n && sinks(b, r)) b = r;
      if (b == k) break;
      swap(k, b);
      k = b;
    end
  endfunction

  function void note_command(cmd_code_t c, logic [31:0] f, logic [31:0] g,
                             logic [15:0] x, logic [15:0] y);
    heap_result_t e;
    logic [31:0] pos;
    int k;
    e = '0;
    pos = {y, x};
    case (c)
      CMD_INSERT: begin
        if (n >= CAP) e.st = ST_FULL;
        else begin
          hf[n] = f; hg[n] = g; hp[n] = pos;
          n++;
          climb(n - 1);
        end
      end
      CMD_EXTRACT: begin
        if (n == 0) e.st = ST_EMPTY;
        else begin
          e.f = hf[0]; e.g = hg[0]; e.x = hp[0][15:0]; e.y = hp[0][31:16];
          n--;
          hf[0] = hf[n]; hg[0] = hg[n]; hp[0] = hp[n];
          descend();
        end
      end
      CMD_DECREASE: begin
        k = 0;
        while (k < n && hp[k] != pos) k++;
        if (k >= n) e.st = ST_NOTFOUND;
        else begin
          hf[k] = f; hg[k] = g;
          climb(k);
        end
      end
      default: ;
    endcase
    e.cnt = 11'(n);
    e.top = n ? hf[0] : '0;
    pending = {pending, e};
  endfunction

  function void check_result(heap_result_t a);
    heap_result_t e;
    if (pending.size() == 0) begin
      $error("result word with nothing expected");
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    if (a.f !== e.f) begin $error("out_f exp %h got %h", e.f, a.f); errors++; end
    if (a.g !== e.g) begin $error("out_g exp %h got %h", e.g, a.g); errors++; end
    if (a.x !== e.x) begin $error("out_x exp %h got %h", e.x, a.x); errors++; end
    if (a.y !== e.y) begin $error("out_y exp %h got %h", e.y, a.y); errors++; end
    if (a.st !== e.st) begin $error("status exp %0d got %0d", e.st, a.st); errors++; end
    if (a.cnt !== e.cnt) begin
      $error("count_after exp %0d got %0d", e.cnt, a.cnt); errors++;
    end
    if (a.top !== e.top) begin
      $error("new_top_f exp %h got %h", e.top, a.top); errors++;
    end
  endfunction
endclass

module tb_search_open_list_min_heap;
  logic clk = 0;
  logic rst = 1;
  solh_cmd_if cmd();
  solh_res_if res();
  solh_cfg_if cfg();
  heap_scoreboard sb;
  int idle_cycles = 0;
  bit sink_busy = 1;
  logic [15:0] px[$];
  logic [15:0] py[$];

  localparam int WATCHDOG = 200000;

  search_open_list_min_heap dut (.clk(clk), .rst(rst), .cmd(cmd.sink), .res(res.source),
    .cfg(cfg.sink));

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  function automatic int gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    return $urandom_range(0, 3);
  endfunction

  initial begin
    cmd.valid = 0; cmd.command = CMD_INSERT; cmd.entry_f = 0; cmd.entry_g = 0;
    cmd.entry_x = 0; cmd.entry_y = 0;
    cfg.valid = 0; cfg.data = 0;
    res.ready = 0;
    sb = new();
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd.valid && cmd.ready)
        sb.note_command(cmd_code_t'(cmd.command), cmd.entry_f, cmd.entry_g,
                        cmd.entry_x, cmd.entry_y);
      if (res.valid && res.ready)
        sb.check_result({res.out_f, res.out_g, res.out_x, res.out_y, res.status,
                         res.count_after, res.new_top_f});
      if ((cmd.valid && cmd.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
        idle_cycles = 0;
      else if (sb.pending.size() != 0 || cmd.valid || cfg.valid)
        idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("tb_search_open_list_min_heap failed");
        $finish;
      end
    end
  end

  // random stalls on the result side
  always @(negedge clk) begin
    if (!sink_busy) res.ready <= 1;
    else if ($urandom_range(0, 15) == 0) res.ready <= 0;
    else if ($urandom_range(0, 1)) res.ready <= ($urandom_range(0, 9) != 0);
    else res.ready <= 1;
  end

  task automatic send(cmd_code_t c, logic [31:0] f, logic [31:0] g,
                      logic [15:0] x, logic [15:0] y);
    @(negedge clk);
    cmd.valid <= 1; cmd.command <= c; cmd.entry_f <= f; cmd.entry_g <= g;
    cmd.entry_x <= x; cmd.entry_y <= y;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    @(negedge clk);
    cmd.valid <= 0;
    repeat (gap()) @(negedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_cfg(bit v);
    drain();
    @(negedge clk);
    cfg.valid <= 1; cfg.data <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    sb.small_g = v;
    @(negedge clk);
    cfg.valid <= 0;
  endtask

  task automatic rand_insert(int f_span);
    logic [15:0] x, y;
    x = 16'($urandom); y = 16'($urandom);
    px = {px, x}; py = {py, y};
    if (px.size() > 64) begin void'(px.pop_front()); void'(py.pop_front()); end
    send(CMD_INSERT, (f_span == 0) ? $urandom : $urandom_range(0, f_span),
         $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3), x, y);
  endtask

  task automatic rand_op(int f_span);
    int r, i;
    r = $urandom_range(0, 99);
    if (r < 45) rand_insert(f_span);
    else if (r < 80) send(CMD_EXTRACT, $urandom, $urandom, 16'($urandom), 16'($urandom));
    else if (r < 96 && px.size() > 0) begin
      i = $urandom_range(0, px.size() - 1);
      send(CMD_DECREASE, (f_span == 0) ? $urandom : $urandom_range(0, f_span),
           $urandom_range(0, 3), px[i], py[i]);
    end else if (r < 98)
      send(CMD_DECREASE, $urandom, $urandom, 16'($urandom), 16'($urandom));
    else send(CMD_NONE, $urandom, $urandom, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed
    send(CMD_EXTRACT, 0, 0, 0, 0);
    send(CMD_DECREASE, 1, 1, 7, 7);
    send(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send(CMD_INSERT, 0, 0, 0, 0);
    send(CMD_INSERT, 5, 2, 1, 2);
    send(CMD_INSERT, 5, 2, 3, 4);
    send(CMD_INSERT, 5, 1, 5, 6);
    send(CMD_INSERT, 5, 3, 16'h5555, 16'hAAAA);
    send(CMD_DECREASE, 0, 9, 16'hFFFF, 16'hFFFF);
    send(CMD_DECREASE, 32'hFFFF_FFFF, 0, 16'h5555, 16'hAAAA);
    send(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    repeat (8) send(CMD_EXTRACT, 0, 0, 0, 0);
    write_cfg(0);
    send(CMD_INSERT, 5, 2, 1, 1);
    send(CMD_INSERT, 5, 9, 2, 2);
    send(CMD_INSERT, 5, 2, 3, 3);
    repeat (4) send(CMD_EXTRACT, 0, 0, 0, 0);
    // random phases, small heaps keep decrease-key search short
    for (int ph = 0; ph < 4; ph++) begin
      write_cfg(ph[0]);
      for (int i = 0; i < 50; i++) rand_op(ph < 2 ? 15 : 0);
      drain();
    end
    px.delete(); py.delete();
    // fill to capacity and overflow
    write_cfg(1);
    sink_busy = 0;
    while (sb.n < 1024) send(CMD_INSERT, $urandom_range(0, 255), $urandom_range(0, 3),
                             16'($urandom), 16'($urandom));
    send(CMD_INSERT, 1, 1, 1, 1);
    send(CMD_INSERT, 1, 1, 1, 1);
    drain();
    sink_busy = 1;
    repeat (700) send(CMD_EXTRACT, 0, 0, 0, 0);
    drain();
    $display("covered empty/full/not-found cases, both g tie-break settings, %0d results",
             sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_search_open_list_min_heap passed");
    else
      $display("tb_search_open_list_min_heap failed");
    $finish;
  end
endmodule
